@@ hdl/utd_pkg.sv @@
// ----------------------------------------------------------------------------
// utd_pkg
// Shared types and constants for the UTF-8 text event decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utd_pkg;

	localparam int ByteW  = 8;
	localparam int CpW    = 21;
	localparam int TdataW = 24;
	localparam int AddrW  = 3;

	// event kinds
	typedef enum logic [2:0] {
		EV_GLYPH   = 3'd0,
		EV_SPACE   = 3'd1,
		EV_NEWLINE = 3'd2,
		EV_RETURN  = 3'd3,
		EV_ADVANCE = 3'd4
	} kind_t;

	// line modes (code 3 acts as MODE_LF)
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_LF    = 2'd0;
	localparam mode_t MODE_SLASH = 2'd1;
	localparam mode_t MODE_SPLIT = 2'd2;

	// register index of line_mode
	localparam logic REG_LINE_MODE = 1'b0;

	localparam logic [CpW-1:0] CH_SLASH = 21'h00002f;
	localparam logic [CpW-1:0] CH_QMARK = 21'h00003f;

	typedef struct packed {
		kind_t          kind;
		logic [CpW-1:0] cp;
		logic           last;
	} event_t;

	typedef struct packed {
		logic   valid;
		event_t ev;
	} opt_event_t;

	// events produced by one byte, compacted: ev0 first
	typedef struct packed {
		logic [1:0] n;
		event_t     ev0;
		event_t     ev1;
	} push_t;

endpackage

`default_nettype wire

@@ hdl/utd_decode.sv @@
// ----------------------------------------------------------------------------
// utd_decode
// Combinational decode of one byte against the open-sequence state: gives
// up to two events and the next accumulator and pending count.
// ----------------------------------------------------------------------------
`default_nettype none

module utd_decode (
	input  wire logic [7:0]       data_byte,
	input  wire logic [20:0]      acc,
	input  wire logic [1:0]       pend,
	input  wire utd_pkg::mode_t   line_mode,
	output utd_pkg::push_t        push,
	output logic [20:0]           acc_nxt,
	output logic [1:0]            pend_nxt
);
	import utd_pkg::*;

	localparam logic [7:0] B_NUL   = 8'h00;
	localparam logic [7:0] B_TAB   = 8'h09;
	localparam logic [7:0] B_SPACE = 8'h20;
	localparam logic [CpW-1:0] C_TAB  = 21'd9;
	localparam logic [CpW-1:0] C_LF   = 21'd10;
	localparam logic [CpW-1:0] C_CR   = 21'd13;
	localparam logic [CpW-1:0] C_CTRL = 21'd32;

	// one complete character value to an event
	function automatic opt_event_t char_event(input logic [CpW-1:0] cp, input mode_t mode);
		opt_event_t r;
		r.valid   = 1'b1;
		r.ev.kind = EV_GLYPH;
		r.ev.cp   = cp;
		r.ev.last = 1'b1;
		if (cp == C_CR || cp == C_LF) begin
			if (mode == MODE_SLASH) begin
				r.ev.cp = CH_SLASH;
			end else if (mode == MODE_SPLIT) begin
				r.ev.kind = (cp == C_CR) ? EV_RETURN : EV_ADVANCE;
				r.ev.cp   = '0;
			end else if (cp == C_LF) begin
				r.ev.kind = EV_NEWLINE;
				r.ev.cp   = '0;
			end else begin
				r.valid = 1'b0;
			end
		end else if (cp < C_CTRL && cp != C_TAB) begin
			r.ev.cp = CH_QMARK;
		end
		return r;
	endfunction

	opt_event_t      fr;
	logic            fr_open;
	logic [CpW-1:0]  fr_acc;
	logic [1:0]      fr_pend;
	opt_event_t      e0, e1, qm;
	logic [CpW-1:0]  cat;

	// byte taken with no sequence open
	always_comb begin
		fr      = '0;
		fr_open = 1'b0;
		fr_acc  = '0;
		fr_pend = '0;
		if (data_byte == B_NUL) begin
			fr = '0;
		end else if (data_byte == B_SPACE || data_byte == B_TAB) begin
			fr.valid   = 1'b1;
			fr.ev.kind = EV_SPACE;
			fr.ev.cp   = '0;
			fr.ev.last = 1'b1;
		end else if (data_byte[7]) begin
			if ((data_byte & 8'hf8) == 8'hf0) begin
				fr_open = 1'b1;
				fr_acc  = {18'd0, data_byte[2:0]};
				fr_pend = 2'd3;
			end else if ((data_byte & 8'he0) == 8'he0) begin
				fr_open = 1'b1;
				fr_acc  = {17'd0, data_byte[3:0]};
				fr_pend = 2'd2;
			end else if ((data_byte & 8'hc0) == 8'hc0) begin
				fr_open = 1'b1;
				fr_acc  = {16'd0, data_byte[4:0]};
				fr_pend = 2'd1;
			end
		end else begin
			fr = char_event({13'd0, data_byte}, line_mode);
		end
	end

	// sequence handling
	always_comb begin
		qm.valid   = 1'b1;
		qm.ev.kind = EV_GLYPH;
		qm.ev.cp   = CH_QMARK;
		qm.ev.last = 1'b1;
		cat        = {acc[14:0], data_byte[5:0]};
		acc_nxt    = acc;
		pend_nxt   = pend;
		e0         = '0;
		e1         = '0;
		if (pend != 2'd0) begin
			if (data_byte == B_NUL) begin
				acc_nxt  = '0;
				pend_nxt = '0;
			end else if (data_byte[7:6] == 2'b10) begin
				pend_nxt = 2'(pend - 2'd1);
				if (pend == 2'd1) begin
					acc_nxt = '0;
					e0      = char_event(cat, line_mode);
				end else begin
					acc_nxt = cat;
				end
			end else begin
				// broken sequence: '?' then the byte again
				e0       = qm;
				e1       = fr;
				acc_nxt  = fr_open ? fr_acc : '0;
				pend_nxt = fr_open ? fr_pend : 2'd0;
			end
		end else begin
			e0 = fr;
			if (fr_open) begin
				acc_nxt  = fr_acc;
				pend_nxt = fr_pend;
			end
		end
	end

	// compact and mark the final event
	always_comb begin
		push = '0;
		if (e0.valid && e1.valid) begin
			push.n        = 2'd2;
			push.ev0      = e0.ev;
			push.ev0.last = 1'b0;
			push.ev1      = e1.ev;
		end else if (e0.valid) begin
			push.n   = 2'd1;
			push.ev0 = e0.ev;
		end else if (e1.valid) begin
			push.n   = 2'd1;
			push.ev0 = e1.ev;
		end
	end

endmodule

`default_nettype wire

@@ hdl/utd_evq.sv @@
// ----------------------------------------------------------------------------
// utd_evq
// Two-entry result queue: takes up to two events per cycle, gives one beat
// per cycle on the output stream while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module utd_evq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire utd_pkg::push_t  push,
	output logic [1:0]           cnt,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [23:0]          m_tdata,  // [2:0] event_kind, [23:3] code_point
	output logic                 m_tlast   // last_of_run
);
	import utd_pkg::*;

	event_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;
	event_t     head;

	assign pop      = (cnt_q != 2'd0) && m_tready;
	assign head     = mem_q[rd_q];
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {head.cp, head.kind};
	assign m_tlast  = head.last;
	assign cnt      = cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			wr_q  <= wr_q ^ push.n[0];
			rd_q  <= rd_q ^ pop;
			cnt_q <= 2'(cnt_q + push.n - {1'b0, pop});
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.ev0;
		end
		if (push.n == 2'd2) begin
			mem_q[~wr_q] <= push.ev1;
		end
	end

endmodule

`default_nettype wire

@@ hdl/utf8_text_event_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_text_event_decoder
// UTF-8 byte stream to text events (glyph, space, line control).
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_*: one text byte per beat in s_tdata; 0 ends the string
//    and drops any open multi-byte sequence.
//  - Output stream m_*: one event per beat; m_tlast marks the final event
//    caused by an input byte (a broken sequence gives '?' then the event of
//    the byte that broke it).
//  - APB port: register line_mode at address 0, written while idle.
//  - A byte passes the input register, then the result queue, before its first event shows.
//  - Throughput: one byte per cycle while the result queue has room; a byte
//    giving two events holds the input stage until the two-entry result queue
//    is empty. Rate is bounded by the one-beat-per-cycle queue drain.
//  - Reset clears the sequence state, line_mode (to 0) and both stages.
//  - When m_tready is low, the queue fills (two events) and s_tready drops
//    once the held byte gives an event; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_text_event_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [2:0] event_kind, [23:3] code_point
	output logic             m_tlast,   // last_of_run
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import utd_pkg::*;

	mode_t       line_mode_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [20:0] acc_q;
	logic [1:0]  pend_q;
	logic [20:0] acc_nxt;
	logic [1:0]  pend_nxt;
	push_t       dec;
	push_t       push;
	logic [1:0]  cnt;
	logic        consume;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LINE_MODE) ? {30'd0, line_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q <= MODE_LF;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_MODE) begin
			line_mode_q <= pwdata[1:0];
		end
	end

	// decode of the registered byte
	utd_decode u_decode (
		.data_byte (byte_s1),
		.acc       (acc_q),
		.pend      (pend_q),
		.line_mode (line_mode_q),
		.push      (dec),
		.acc_nxt   (acc_nxt),
		.pend_nxt  (pend_nxt)
	);

	// byte moves on when the queue has room for all its events
	assign consume  = valid_s1 && (({1'b0, dec.n} + {1'b0, cnt}) <= 3'd2);
	assign s_tready = !valid_s1 || consume;

	always_comb begin
		push = dec;
		if (!consume) begin
			push.n = 2'd0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
		end else if (consume) begin
			acc_q  <= acc_nxt;
			pend_q <= pend_nxt;
		end
	end

	// result queue
	utd_evq u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.cnt      (cnt),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

@@ hdl/utd_checker.sv @@
// ----------------------------------------------------------------------------
// utd_checker
// Port-level checks for the UTF-8 text event decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tlast
);
	import utd_pkg::*;

	// stalled beat stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	// stalled beat keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("m_tdata changed while stalled");

	// only glyph events carry a code point
	a_cp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != EV_GLYPH |-> m_tdata[23:3] == '0)
		else $error("non-glyph event with nonzero code point");

	// a non-final event of a byte is always the '?' of a broken sequence
	a_first_qmark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[2:0] == EV_GLYPH && m_tdata[23:3] == CH_QMARK)
		else $error("non-final event is not the broken-sequence mark");

endmodule

bind utf8_text_event_decoder utd_checker u_utd_checker (.*);

`default_nettype wire
